// ===== sv/gpf_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register indexes and stage payload types for the pair force unit.
package gpf_pkg;

  localparam int POS_W       = 32;
  localparam int MASS_W      = 32;
  localparam int SCALE_W     = 32;
  localparam int MIN_W       = 64;
  localparam int MAG_W       = 32;
  localparam int DELTA_W     = MAG_W + 1;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int D2_W        = SQ_W + 1;
  localparam int M12_W       = 2 * MASS_W;
  localparam int P_W         = M12_W + SCALE_W;
  localparam int RAD_W       = 98;
  localparam int ROOT_W      = 49;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DEN_W       = 114;
  localparam int NUM_W       = MAG_W + P_W;
  localparam int NUM_SHIFT   = 16;
  localparam int Q_W         = 32;
  localparam int DIV_STEPS   = Q_W;
  localparam int FORCE_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [SCALE_W-1:0] GRAV_SCALE_RST = 32'd65536;
  localparam logic [MIN_W-1:0]   MIN_DIST_RST   = 64'd4295;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST   = 2'd1;

  localparam logic [Q_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic [P_W-1:0]   p;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic             neg_x;
    logic             neg_y;
    logic             coinc;
    logic [D2_W-1:0]  d2;
  } gpf_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             coinc;
  } gpf_div_in_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           ovf;
    logic           neg;
    logic           coinc;
  } gpf_div_out_t;

  typedef struct packed {
    logic [FORCE_W-1:0] force_x;
    logic [FORCE_W-1:0] force_y;
    logic               coinc;
    logic               sat;
  } gpf_result_t;

endpackage

// ===== sv/gpf_front.sv =====
`timescale 1ns / 1ps
// Front stages: position deltas, squared distance, mass product and coincidence test.
module gpf_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [gpf_pkg::POS_W-1:0] first_x,
  input  logic signed [gpf_pkg::POS_W-1:0] first_y,
  input  logic signed [gpf_pkg::POS_W-1:0] second_x,
  input  logic signed [gpf_pkg::POS_W-1:0] second_y,
  input  logic [gpf_pkg::MASS_W-1:0]     first_mass,
  input  logic [gpf_pkg::MASS_W-1:0]     second_mass,
  input  logic [gpf_pkg::SCALE_W-1:0]    grav_scale,
  input  logic [gpf_pkg::MIN_W-1:0]      min_dist_squared,
  output logic                           out_valid,
  output gpf_pkg::gpf_side_t             side
);

  logic [gpf_pkg::DELTA_W-1:0] dx;
  logic [gpf_pkg::DELTA_W-1:0] dy;
  logic [gpf_pkg::DELTA_W-1:0] dx_abs;
  logic [gpf_pkg::DELTA_W-1:0] dy_abs;

  logic                        v1;
  logic [gpf_pkg::MAG_W-1:0]   ax1;
  logic [gpf_pkg::MAG_W-1:0]   ay1;
  logic                        neg_x1;
  logic                        neg_y1;
  logic [gpf_pkg::M12_W-1:0]   m12_1;

  logic                        v2;
  logic [gpf_pkg::MAG_W-1:0]   ax2;
  logic [gpf_pkg::MAG_W-1:0]   ay2;
  logic                        neg_x2;
  logic                        neg_y2;
  logic [gpf_pkg::SQ_W-1:0]    sx2;
  logic [gpf_pkg::SQ_W-1:0]    sy2;
  logic [gpf_pkg::SQ_W-1:0]    pl2;
  logic [gpf_pkg::SQ_W-1:0]    ph2;

  logic                        v3;
  logic [gpf_pkg::MAG_W-1:0]   ax3;
  logic [gpf_pkg::MAG_W-1:0]   ay3;
  logic                        neg_x3;
  logic                        neg_y3;
  logic [gpf_pkg::D2_W-1:0]    d2_3;
  logic [gpf_pkg::P_W-1:0]     p3;

  always_comb begin
    dx = {second_x[gpf_pkg::POS_W-1], second_x} - {first_x[gpf_pkg::POS_W-1], first_x};
    dy = {second_y[gpf_pkg::POS_W-1], second_y} - {first_y[gpf_pkg::POS_W-1], first_y};
    dx_abs = dx[gpf_pkg::DELTA_W-1] ? (gpf_pkg::DELTA_W'(0) - dx) : dx;
    dy_abs = dy[gpf_pkg::DELTA_W-1] ? (gpf_pkg::DELTA_W'(0) - dy) : dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1    <= dx_abs[gpf_pkg::MAG_W-1:0];
      ay1    <= dy_abs[gpf_pkg::MAG_W-1:0];
      neg_x1 <= dx[gpf_pkg::DELTA_W-1];
      neg_y1 <= dy[gpf_pkg::DELTA_W-1];
      m12_1  <= gpf_pkg::M12_W'(first_mass) * gpf_pkg::M12_W'(second_mass);

      ax2    <= ax1;
      ay2    <= ay1;
      neg_x2 <= neg_x1;
      neg_y2 <= neg_y1;
      sx2    <= gpf_pkg::SQ_W'(ax1) * gpf_pkg::SQ_W'(ax1);
      sy2    <= gpf_pkg::SQ_W'(ay1) * gpf_pkg::SQ_W'(ay1);
      pl2    <= gpf_pkg::SQ_W'(m12_1[31:0]) * gpf_pkg::SQ_W'(grav_scale);
      ph2    <= gpf_pkg::SQ_W'(m12_1[63:32]) * gpf_pkg::SQ_W'(grav_scale);

      ax3    <= ax2;
      ay3    <= ay2;
      neg_x3 <= neg_x2;
      neg_y3 <= neg_y2;
      d2_3   <= gpf_pkg::D2_W'(sx2) + gpf_pkg::D2_W'(sy2);
      p3     <= {ph2, 32'd0} + gpf_pkg::P_W'(pl2);
    end
  end

  assign out_valid  = v3;
  assign side.p     = p3;
  assign side.ax    = ax3;
  assign side.ay    = ay3;
  assign side.neg_x = neg_x3;
  assign side.neg_y = neg_y3;
  assign side.d2    = d2_3;
  assign side.coinc = (d2_3 < gpf_pkg::D2_W'(min_dist_squared)) || (d2_3 == '0);

endmodule

// ===== sv/gpf_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root of the squared distance, one root bit per stage.
module gpf_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  gpf_pkg::gpf_side_t          side_in,
  output logic                        out_valid,
  output logic [gpf_pkg::ROOT_W-1:0]  root,
  output gpf_pkg::gpf_side_t          side_out
);

  localparam int N = gpf_pkg::SQRT_STAGES;

  logic [N-1:0]                vld;
  logic [gpf_pkg::RAD_W-1:0]   rad_q  [N];
  logic [gpf_pkg::REM_W-1:0]   rem_q  [N];
  logic [gpf_pkg::ROOT_W-1:0]  root_q [N];
  gpf_pkg::gpf_side_t          side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                        v_i;
    logic [gpf_pkg::RAD_W-1:0]   rad_i;
    logic [gpf_pkg::REM_W-1:0]   rem_i;
    logic [gpf_pkg::ROOT_W-1:0]  root_i;
    gpf_pkg::gpf_side_t          side_i;
    logic [gpf_pkg::REM_W+1:0]   sh;
    logic [gpf_pkg::REM_W+1:0]   trial;
    logic [gpf_pkg::REM_W+1:0]   diff;
    logic                        ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = {1'b0, side_in.d2, 32'd0};
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign v_i    = vld[k-1];
      assign rad_i  = rad_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign side_i = side_q[k-1];
    end

    always_comb begin
      sh    = {rem_i, rad_i[gpf_pkg::RAD_W-1 -: 2]};
      trial = {2'b00, root_i, 2'b01};
      ge    = sh >= trial;
      diff  = sh - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= rad_i << 2;
        rem_q[k]  <= ge ? diff[gpf_pkg::REM_W-1:0] : sh[gpf_pkg::REM_W-1:0];
        root_q[k] <= {root_i[gpf_pkg::ROOT_W-2:0], ge};
        side_q[k] <= side_i;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign root      = root_q[N-1];
  assign side_out  = side_q[N-1];

endmodule

// ===== sv/gpf_mul.sv =====
`timescale 1ns / 1ps
// Split-operand multiplies for the divisor r*d2 and the two force numerators.
module gpf_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [gpf_pkg::ROOT_W-1:0]  root,
  input  gpf_pkg::gpf_side_t          side,
  output logic                        out_valid,
  output gpf_pkg::gpf_div_in_t        div_x,
  output gpf_pkg::gpf_div_in_t        div_y
);

  logic        v1, v2, v3;
  logic        neg_x1, neg_y1, coinc1;
  logic        neg_x2, neg_y2, coinc2;
  logic        neg_x3, neg_y3, coinc3;

  logic [63:0] pp00;
  logic [64:0] pp01;
  logic [48:0] pp10;
  logic [49:0] pp11;
  logic [63:0] nx0, nx1, nx2;
  logic [63:0] ny0, ny1, ny2;

  logic [65:0]                  mid2;
  logic [gpf_pkg::DEN_W-1:0]    lohi2;
  logic [gpf_pkg::NUM_W-1:0]    num_x2, num_y2;

  logic [gpf_pkg::DEN_W-1:0]    den3;
  logic [gpf_pkg::NUM_W-1:0]    num_x3, num_y3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00   <= 64'(root[31:0]) * 64'(side.d2[31:0]);
      pp01   <= 65'(root[31:0]) * 65'(side.d2[64:32]);
      pp10   <= 49'(root[48:32]) * 49'(side.d2[31:0]);
      pp11   <= 50'(root[48:32]) * 50'(side.d2[64:32]);
      nx0    <= 64'(side.ax) * 64'(side.p[31:0]);
      nx1    <= 64'(side.ax) * 64'(side.p[63:32]);
      nx2    <= 64'(side.ax) * 64'(side.p[95:64]);
      ny0    <= 64'(side.ay) * 64'(side.p[31:0]);
      ny1    <= 64'(side.ay) * 64'(side.p[63:32]);
      ny2    <= 64'(side.ay) * 64'(side.p[95:64]);
      neg_x1 <= side.neg_x;
      neg_y1 <= side.neg_y;
      coinc1 <= side.coinc;

      mid2   <= 66'(pp01) + 66'(pp10);
      lohi2  <= {pp11, pp00};
      num_x2 <= {nx2, nx0} + {32'd0, nx1, 32'd0};
      num_y2 <= {ny2, ny0} + {32'd0, ny1, 32'd0};
      neg_x2 <= neg_x1;
      neg_y2 <= neg_y1;
      coinc2 <= coinc1;

      den3   <= lohi2 + gpf_pkg::DEN_W'({mid2, 32'd0});
      num_x3 <= num_x2;
      num_y3 <= num_y2;
      neg_x3 <= neg_x2;
      neg_y3 <= neg_y2;
      coinc3 <= coinc2;
    end
  end

  assign out_valid   = v3;
  assign div_x.num   = num_x3;
  assign div_x.den   = den3;
  assign div_x.neg   = neg_x3;
  assign div_x.coinc = coinc3;
  assign div_y.num   = num_y3;
  assign div_y.den   = den3;
  assign div_y.neg   = neg_y3;
  assign div_y.coinc = coinc3;

endmodule

// ===== sv/gpf_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider giving a 32-bit quotient of num*2^16/den and an overflow flag.
module gpf_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  gpf_pkg::gpf_div_in_t  din,
  output logic                  out_valid,
  output gpf_pkg::gpf_div_out_t dout
);

  localparam int N   = gpf_pkg::DIV_STEPS + 1;
  localparam int HI_W = gpf_pkg::NUM_W - gpf_pkg::NUM_SHIFT;

  logic [N-1:0]                vld;
  logic [gpf_pkg::DEN_W-1:0]   rem_q [N];
  logic [gpf_pkg::DEN_W-1:0]   den_q [N];
  logic [gpf_pkg::Q_W-1:0]     low_q [N];
  logic [gpf_pkg::Q_W-1:0]     quo_q [N];
  logic [N-1:0]                ovf_q;
  logic [N-1:0]                neg_q;
  logic [N-1:0]                coinc_q;

  logic [gpf_pkg::DEN_W-1:0]   hi0;
  logic                        ovf0;

  always_comb begin
    hi0  = gpf_pkg::DEN_W'(din.num[gpf_pkg::NUM_W-1:gpf_pkg::NUM_SHIFT]);
    ovf0 = hi0 >= din.den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]   <= ovf0 ? '0 : hi0;
      den_q[0]   <= din.den;
      low_q[0]   <= {din.num[gpf_pkg::NUM_SHIFT-1:0], 16'd0};
      quo_q[0]   <= '0;
      ovf_q[0]   <= ovf0;
      neg_q[0]   <= din.neg;
      coinc_q[0] <= din.coinc;
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_step
    logic [gpf_pkg::DEN_W:0] sh;
    logic [gpf_pkg::DEN_W:0] diff;
    logic                    ge;

    always_comb begin
      sh   = {rem_q[k-1], low_q[k-1][gpf_pkg::Q_W-1]};
      diff = sh - {1'b0, den_q[k-1]};
      ge   = sh >= {1'b0, den_q[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]   <= ge ? diff[gpf_pkg::DEN_W-1:0] : sh[gpf_pkg::DEN_W-1:0];
        den_q[k]   <= den_q[k-1];
        low_q[k]   <= low_q[k-1] << 1;
        quo_q[k]   <= {quo_q[k-1][gpf_pkg::Q_W-2:0], ge};
        ovf_q[k]   <= ovf_q[k-1];
        neg_q[k]   <= neg_q[k-1];
        coinc_q[k] <= coinc_q[k-1];
      end
    end
  end

  assign out_valid  = vld[N-1];
  assign dout.q     = quo_q[N-1];
  assign dout.ovf   = ovf_q[N-1];
  assign dout.neg   = neg_q[N-1];
  assign dout.coinc = coinc_q[N-1];

endmodule

// ===== sv/gravity_pair_force_unit.sv =====
`timescale 1ns / 1ps
// Top level of the 2-D gravitational pair force unit.
// Usage: each input beat carries one body pair (positions and masses, Q16.16) and
// yields exactly one output beat with the force on the first body, a coincident flag
// and a saturation flag. Input beats are taken when in_valid is high and in_stall low;
// output beats are delivered when out_valid is high and out_stall low.
// Throughput is one pair per cycle while in_stall is low. An accepted input beat passes
// through 3 front stages, 49 square root stages (one root bit each), 3 multiply
// stages, 33 divider stages (overflow check plus one quotient bit each), and the
// output register before it appears with out_valid.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 sets the gravity scale and index 1 sets min_dist_squared, other
// indexes are ignored. Write it only while no pairs are in flight.
// Reset clears all valid bits and loads a gravity scale of 1.0 and
// min_dist_squared = 4295.
// When the receiver stalls, a one-entry skid buffer behind the output register takes
// the next result; the pipeline then freezes and in_stall rises until the skid drains.
module gravity_pair_force_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [gpf_pkg::POS_W-1:0]     first_x,
  input  logic signed [gpf_pkg::POS_W-1:0]     first_y,
  input  logic signed [gpf_pkg::POS_W-1:0]     second_x,
  input  logic signed [gpf_pkg::POS_W-1:0]     second_y,
  input  logic [gpf_pkg::MASS_W-1:0]           first_mass,
  input  logic [gpf_pkg::MASS_W-1:0]           second_mass,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gpf_pkg::FORCE_W-1:0]   force_x,
  output logic signed [gpf_pkg::FORCE_W-1:0]   force_y,
  output logic                                 coincident,
  output logic                                 saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gpf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [gpf_pkg::SCALE_W-1:0] grav_scale;
  logic [gpf_pkg::MIN_W-1:0]   min_dist_squared;

  logic                        en;
  logic                        front_valid;
  gpf_pkg::gpf_side_t          front_side;
  logic                        sqrt_valid;
  logic [gpf_pkg::ROOT_W-1:0]  sqrt_root;
  gpf_pkg::gpf_side_t          sqrt_side;
  logic                        mul_valid;
  gpf_pkg::gpf_div_in_t        div_x_in;
  gpf_pkg::gpf_div_in_t        div_y_in;
  logic                        div_x_valid;
  logic                        div_y_valid;
  gpf_pkg::gpf_div_out_t       div_x_out;
  gpf_pkg::gpf_div_out_t       div_y_out;

  logic [gpf_pkg::Q_W-1:0]     lim_x, lim_y, mag_x, mag_y;
  logic                        sat_x, sat_y;
  gpf_pkg::gpf_result_t        result;

  logic                        out_take;
  logic                        skid_valid;
  gpf_pkg::gpf_result_t        skid;
  gpf_pkg::gpf_result_t        out_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_scale       <= gpf_pkg::GRAV_SCALE_RST;
      min_dist_squared <= gpf_pkg::MIN_DIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gpf_pkg::CFG_GRAV_SCALE: grav_scale <= cfg_data[gpf_pkg::SCALE_W-1:0];
        gpf_pkg::CFG_MIN_DIST:   min_dist_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  gpf_front u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (in_valid),
    .first_x          (first_x),
    .first_y          (first_y),
    .second_x         (second_x),
    .second_y         (second_y),
    .first_mass       (first_mass),
    .second_mass      (second_mass),
    .grav_scale       (grav_scale),
    .min_dist_squared (min_dist_squared),
    .out_valid        (front_valid),
    .side             (front_side)
  );

  gpf_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .side_in   (front_side),
    .out_valid (sqrt_valid),
    .root      (sqrt_root),
    .side_out  (sqrt_side)
  );

  gpf_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sqrt_valid),
    .root      (sqrt_root),
    .side      (sqrt_side),
    .out_valid (mul_valid),
    .div_x     (div_x_in),
    .div_y     (div_y_in)
  );

  gpf_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mul_valid),
    .din       (div_x_in),
    .out_valid (div_x_valid),
    .dout      (div_x_out)
  );

  gpf_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mul_valid),
    .din       (div_y_in),
    .out_valid (div_y_valid),
    .dout      (div_y_out)
  );

  always_comb begin
    lim_x = div_x_out.neg ? gpf_pkg::NEG_LIMIT : gpf_pkg::POS_LIMIT;
    lim_y = div_y_out.neg ? gpf_pkg::NEG_LIMIT : gpf_pkg::POS_LIMIT;
    sat_x = div_x_out.ovf || (div_x_out.q > lim_x);
    sat_y = div_y_out.ovf || (div_y_out.q > lim_y);
    mag_x = sat_x ? lim_x : div_x_out.q;
    mag_y = sat_y ? lim_y : div_y_out.q;
    if (div_x_out.coinc) begin
      result.force_x = '0;
      result.force_y = '0;
      result.coinc   = 1'b1;
      result.sat     = 1'b0;
    end else begin
      result.force_x = div_x_out.neg ? (gpf_pkg::Q_W'(0) - mag_x) : mag_x;
      result.force_y = div_y_out.neg ? (gpf_pkg::Q_W'(0) - mag_y) : mag_y;
      result.coinc   = 1'b0;
      result.sat     = sat_x || sat_y;
    end
  end

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= div_x_valid;
    end else if (div_x_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_reg <= skid;
      end
    end else if (!out_valid || out_take) begin
      out_reg <= result;
    end else begin
      skid <= result;
    end
  end

  assign force_x    = out_reg.force_x;
  assign force_y    = out_reg.force_y;
  assign coincident = out_reg.coinc;
  assign saturated  = out_reg.sat;

  assert property (@(posedge clk) disable iff (rst) div_x_valid == div_y_valid)
    else $error("Divider lanes lost step with each other.");

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("Skid buffer holds a beat while the output register is empty.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && coincident) |-> (force_x == '0 && force_y == '0 && !saturated))
    else $error("Coincident result carries a nonzero force or saturation.");

  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |=> $stable(out_reg))
    else $error("Output beat changed while the receiver stalled.");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the pair force unit: random and corner pairs against a predictor.
module testbench;

  typedef struct packed {
    logic [gpf_pkg::POS_W-1:0]  fx;
    logic [gpf_pkg::POS_W-1:0]  fy;
    logic [gpf_pkg::POS_W-1:0]  sx;
    logic [gpf_pkg::POS_W-1:0]  sy;
    logic [gpf_pkg::MASS_W-1:0] m1;
    logic [gpf_pkg::MASS_W-1:0] m2;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [gpf_pkg::POS_W-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic [gpf_pkg::MASS_W-1:0] first_mass = '0, second_mass = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [gpf_pkg::FORCE_W-1:0] force_x, force_y;
  logic coincident, saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gpf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [gpf_pkg::SCALE_W-1:0] gravity_scale = gpf_pkg::GRAV_SCALE_RST;
  logic [gpf_pkg::MIN_W-1:0] near_limit = gpf_pkg::MIN_DIST_RST;
  pair_t pending_pairs[$];
  gpf_pkg::gpf_result_t expected_forces[$];
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_count = 0;

  gravity_pair_force_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [gpf_pkg::FORCE_W-1:0] force_part(logic [32:0] mag, logic neg,
                                                             logic [255:0] num_base,
                                                             logic [255:0] den,
                                                             inout logic sat);
    logic [255:0] q;
    logic [255:0] limit;
    q = (256'(mag) * num_base) / den;
    limit = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
    if (q > limit) begin
      q = limit;
      sat = 1'b1;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic gpf_pkg::gpf_result_t pair_force(pair_t p);
    logic [32:0] dx, dy, ax, ay;
    logic [64:0] d2;
    logic [255:0] rad, sq, den, num_base;
    logic [48:0] root, cand;
    logic sat;
    gpf_pkg::gpf_result_t res;
    res = '0;
    sat = 1'b0;
    dx = {p.sx[31], p.sx} - {p.fx[31], p.fx};
    dy = {p.sy[31], p.sy} - {p.fy[31], p.fy};
    ax = dx[32] ? -dx : dx;
    ay = dy[32] ? -dy : dy;
    d2 = 65'(ax) * 65'(ax) + 65'(ay) * 65'(ay);
    if (d2 == 0 || d2 < {1'b0, near_limit}) begin
      res.coinc = 1'b1;
      return res;
    end
    rad = 256'(d2) << 32;
    root = '0;
    for (int b = 48; b >= 0; b--) begin
      cand = root | (49'd1 << b);
      sq = 256'(cand) * 256'(cand);
      if (sq <= rad) root = cand;
    end
    den = 256'(root) * 256'(d2);
    num_base = (256'(p.m1) * 256'(p.m2) * 256'(gravity_scale)) << 16;
    res.force_x = force_part(ax, dx[32], num_base, den, sat);
    res.force_y = force_part(ay, dy[32], num_base, den, sat);
    res.sat = sat;
    return res;
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    p.fx = $urandom;
    p.fy = $urandom;
    p.m1 = pick_mass();
    p.m2 = pick_mass();
    case ($urandom_range(0, 4))
      0: begin
        p.sx = $urandom;
        p.sy = $urandom;
      end
      1: begin
        p.sx = p.fx + $urandom_range(0, 511) - 256;
        p.sy = p.fy + $urandom_range(0, 511) - 256;
      end
      2: begin
        p.sx = p.fx + $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
        p.sy = p.fy + $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
      end
      3: begin
        p.sx = p.fx + $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
        p.sy = p.fy;
      end
      default: begin
        p.sx = p.fx;
        p.sy = p.fy + $urandom_range(0, 3) - 1;
      end
    endcase
    return p;
  endfunction

  task automatic write_reg(logic [gpf_pkg::CFG_IDX_W-1:0] idx,
                           logic [gpf_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == gpf_pkg::CFG_GRAV_SCALE) gravity_scale = value[gpf_pkg::SCALE_W-1:0];
    else if (idx == gpf_pkg::CFG_MIN_DIST) near_limit = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !in_valid && expected_forces.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic push_pair(logic [31:0] fx, fy, sx, sy, m1, m2);
    pair_t p;
    p = '{fx, fy, sx, sy, m1, m2};
    pending_pairs.push_back(p);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_forces.push_back(pair_force('{first_x, first_y, second_x, second_y,
                                               first_mass, second_mass}));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          pair_t p;
          p = pending_pairs.pop_front();
          first_x <= p.fx;
          first_y <= p.fy;
          second_x <= p.sx;
          second_y <= p.sy;
          first_mass <= p.m1;
          second_mass <= p.m2;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_count++;
      if (stall_count % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= (stall_count % 7 < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_forces.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        gpf_pkg::gpf_result_t e;
        e = expected_forces.pop_front();
        if (force_x !== e.force_x) begin
          $error("force_x expected %h actual %h", e.force_x, force_x);
          errors++;
        end
        if (force_y !== e.force_y) begin
          $error("force_y expected %h actual %h", e.force_y, force_y);
          errors++;
        end
        if (coincident !== e.coinc) begin
          $error("coincident expected %b actual %b", e.coinc, coincident);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated expected %b actual %b", e.sat, saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    push_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    push_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
              32'h0001_0000);
    push_pair(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    push_pair(0, 0, 1, 0, 32'h0001_0000, 32'h0001_0000);
    push_pair(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pair(0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000);
    push_pair(0, 0, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 0);
    push_pair(32'h0010_0000, 0, 0, 32'h0010_0000, 32'h0100_0000, 32'h0100_0000);
    push_pair(0, 0, 32'h0000_1000, 0, 32'h0001_0000, 32'h0001_0000);
    push_pair(0, 0, 32'h0000_1001, 0, 32'h0001_0000, 32'h0001_0000);
    push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'h8000_0000, 32'h0000_0001);
    for (int i = 0; i < 250; i++) pending_pairs.push_back(random_pair());
    drain();

    write_reg(gpf_pkg::CFG_GRAV_SCALE, 64'hFFFF_FFFF);
    write_reg(gpf_pkg::CFG_MIN_DIST, 64'd0);
    push_pair(5, 5, 5, 5, 32'h0001_0000, 32'h0001_0000);
    push_pair(0, 0, 1, 0, 32'h0001_0000, 32'h0001_0000);
    for (int i = 0; i < 250; i++) pending_pairs.push_back(random_pair());
    drain();

    write_reg(gpf_pkg::CFG_GRAV_SCALE, 64'd0);
    write_reg(gpf_pkg::CFG_MIN_DIST, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(2'd2, {$urandom, $urandom});
    write_reg(2'd3, {$urandom, $urandom});
    push_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1);
    for (int i = 0; i < 100; i++) pending_pairs.push_back(random_pair());
    drain();

    write_reg(gpf_pkg::CFG_GRAV_SCALE, 64'd65536);
    write_reg(gpf_pkg::CFG_MIN_DIST, 64'h0000_0001_0000_0000);
    for (int i = 0; i < 200; i++) pending_pairs.push_back(random_pair());
    drain();

    write_reg(gpf_pkg::CFG_GRAV_SCALE, {32'h0, $urandom});
    write_reg(gpf_pkg::CFG_MIN_DIST, {32'h0, $urandom});
    for (int i = 0; i < 200; i++) pending_pairs.push_back(random_pair());
    drain();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/gpf_pkg.sv
sv/gpf_front.sv
sv/gpf_isqrt.sv
sv/gpf_mul.sv
sv/gpf_div.sv
sv/gravity_pair_force_unit.sv
bench/testbench.sv
